>>> hw/rtl/des_pkg.sv
`default_nettype none

package des_pkg;

   localparam int SAMPLE_WIDTH_DEF  = 16;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int GAIN_BITS = 16;
   localparam int GAIN_W    = GAIN_BITS + 1;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_BITS);

   localparam int STATE_W = 32;
   localparam int OPND_W  = STATE_W + 2;
   localparam int PROD_W  = GAIN_W + 1 + OPND_W;

   localparam logic signed [PROD_W-1:0] STATE_MAX_P = PROD_W'((64'sd1 <<< (STATE_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] STATE_MIN_P = -STATE_MAX_P - PROD_W'(1);
   localparam logic signed [STATE_W-1:0] STATE_MAX = STATE_W'((64'sd1 <<< (STATE_W - 1)) - 1);
   localparam logic signed [STATE_W-1:0] STATE_MIN = ~STATE_MAX;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_GAIN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TREND_GAIN = 1'b1;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1 << (GAIN_BITS - 1));

endpackage

`default_nettype wire

>>> hw/rtl/des_mul.sv
`default_nettype none

module des_mul
   import des_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [GAIN_W-1:0]        gain,
   input  wire logic signed [OPND_W-1:0] operand,
   output logic signed [PROD_W-1:0]      product_ff
);

   logic signed [PROD_W-1:0] product_in;

   assign product_in = $signed({1'b0, gain}) * operand;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/double_exponential_smoother.sv
`default_nettype none

// Holt double exponential smoother: each accepted sample updates a signed level and
// trend (FRACTION_BITS fraction bits, zero after reset) with gains alpha (csr index 0)
// and beta (csr index 1), Q1.16 with 65536 as one and larger values used as one.
// One result beat per sample: floor(level + trend) saturated to the sample range, plus
// a flag set when level, trend or the result saturated. A sample passes from acceptance
// to a valid result through states MA, MB, NL, MC, MD, NT and OUT, set by the four
// dependent products that pass through one registered multiplier and the sums between
// them; OUT waits for a free output register, and no new sample enters until it leaves.
// req_ready is high only while the sequencer is idle, and a result waiting in the output
// register still lets the next sample in. Write the gains only while the block is idle.
module double_exponential_smoother
   import des_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_smoothed,
   output logic                               rsp_clipped,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [GAIN_W-1:0]             csr_wdata
);

   localparam int LSH = (FRACTION_BITS >= GAIN_BITS) ? FRACTION_BITS - GAIN_BITS : 0;
   localparam int RSH = (FRACTION_BITS <  GAIN_BITS) ? GAIN_BITS - FRACTION_BITS : 0;

   localparam logic signed [STATE_W:0] SMP_MAX =
      (STATE_W+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [STATE_W:0] SMP_MIN = -SMP_MAX - (STATE_W+1)'(1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MA   = 3'd1;
   localparam logic [2:0] S_MB   = 3'd2;
   localparam logic [2:0] S_NL   = 3'd3;
   localparam logic [2:0] S_MC   = 3'd4;
   localparam logic [2:0] S_MD   = 3'd5;
   localparam logic [2:0] S_NT   = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [GAIN_W-1:0]         alpha_cfg_ff, beta_cfg_ff;
   logic [GAIN_W-1:0]         alpha, beta;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [STATE_W-1:0] level_ff, trend_ff, nl_ff, nt_ff, nl_in, nt_in;
   logic signed [PROD_W-1:0]  acc_ff, acc_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] smoothed_ff, smoothed_in;
   logic                      clipped_ff;
   logic                      y_hit;
   logic [GAIN_W-1:0]         mul_gain;
   logic signed [OPND_W-1:0]  mul_opnd;
   logic signed [PROD_W-1:0]  product;
   logic signed [PROD_W-1:0]  x_term, g_term, sum;
   logic signed [STATE_W:0]   y_full, y_shift;
   logic                      sum_hi, sum_lo, out_free;

   assign alpha = (alpha_cfg_ff > GAIN_ONE) ? GAIN_ONE : alpha_cfg_ff;
   assign beta  = (beta_cfg_ff  > GAIN_ONE) ? GAIN_ONE : beta_cfg_ff;

   always_comb begin
      mul_gain = alpha;
      mul_opnd = OPND_W'(x_ff);
      unique case (state_ff)
         S_MA: begin
            mul_gain = alpha;
            mul_opnd = OPND_W'(x_ff);
         end
         S_MB: begin
            mul_gain = GAIN_ONE - alpha;
            mul_opnd = OPND_W'(level_ff) + OPND_W'(trend_ff);
         end
         S_MC: begin
            mul_gain = beta;
            mul_opnd = OPND_W'(nl_ff) - OPND_W'(level_ff);
         end
         S_MD: begin
            mul_gain = GAIN_ONE - beta;
            mul_opnd = OPND_W'(trend_ff);
         end
         default: begin
            mul_gain = alpha;
            mul_opnd = OPND_W'(x_ff);
         end
      endcase
   end

   des_mul u_mul (
      .clock      (clock),
      .gain       (mul_gain),
      .operand    (mul_opnd),
      .product_ff (product)
   );

   assign x_term = (product <<< LSH) >>> RSH;
   assign g_term = product >>> GAIN_BITS;
   assign sum    = acc_ff + g_term;
   assign sum_hi = sum > STATE_MAX_P;
   assign sum_lo = sum < STATE_MIN_P;

   always_comb begin
      if (sum_hi) begin
         nl_in = STATE_MAX;
      end else if (sum_lo) begin
         nl_in = STATE_MIN;
      end else begin
         nl_in = sum[STATE_W-1:0];
      end
      nt_in = nl_in;
   end

   assign y_full  = (STATE_W+1)'(nl_ff) + (STATE_W+1)'(nt_ff);
   assign y_shift = y_full >>> FRACTION_BITS;

   always_comb begin
      y_hit = 1'b0;
      if (y_shift > SMP_MAX) begin
         smoothed_in = SMP_MAX[SAMPLE_WIDTH-1:0];
         y_hit       = 1'b1;
      end else if (y_shift < SMP_MIN) begin
         smoothed_in = SMP_MIN[SAMPLE_WIDTH-1:0];
         y_hit       = 1'b1;
      end else begin
         smoothed_in = y_shift[SAMPLE_WIDTH-1:0];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MA;
               hit_in   = 1'b0;
            end
         end
         S_MA: state_in = S_MB;
         S_MB: begin
            acc_in   = x_term;
            state_in = S_NL;
         end
         S_NL: begin
            hit_in   = hit_ff | sum_hi | sum_lo;
            state_in = S_MC;
         end
         S_MC: state_in = S_MD;
         S_MD: begin
            acc_in   = g_term;
            state_in = S_NT;
         end
         S_NT: begin
            hit_in   = hit_ff | sum_hi | sum_lo;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_cfg_ff <= GAIN_RESET;
         beta_cfg_ff  <= GAIN_RESET;
         level_ff     <= '0;
         trend_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LEVEL_GAIN: alpha_cfg_ff <= csr_wdata;
               CSR_TREND_GAIN: beta_cfg_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_OUT && out_free) begin
            level_ff     <= nl_ff;
            trend_ff     <= nt_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (req_valid && req_ready) begin
         x_ff <= req_sample;
      end
      if (state_ff == S_NL) begin
         nl_ff <= nl_in;
      end
      if (state_ff == S_NT) begin
         nt_ff <= nt_in;
      end
      if (state_ff == S_OUT && out_free) begin
         smoothed_ff <= smoothed_in;
         clipped_ff  <= hit_ff | y_hit;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_smoothed = smoothed_ff;
   assign rsp_clipped  = clipped_ff;

endmodule

`default_nettype wire
